// File: design/swmo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_pkg
// shared widths, constants and defaults of the sliding window median offset
// ----------------------------------------------------------------------------
package swmo_pkg;

  localparam int unsigned SampleW      = 64;
  localparam int unsigned ThrW         = 32;
  localparam int unsigned CountOutW    = 6;
  localparam int unsigned WindowDef    = 50;
  localparam int unsigned MinForMedian = 5;
  localparam logic [ThrW-1:0] ThrReset = 32'd600;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [ThrW-1:0]           thr_t;
  typedef logic [CountOutW-1:0]      count_out_t;

endpackage

`default_nettype wire

// File: design/swmo_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_in_if
// sample channel: valid, ready and one offset sample
// ----------------------------------------------------------------------------
interface swmo_in_if;

  logic              valid;
  logic              ready;
  swmo_pkg::sample_t offset_sample;

  modport source (output valid, output offset_sample, input ready);
  modport sink (input valid, input offset_sample, output ready);

endinterface

`default_nettype wire

// File: design/swmo_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_out_if
// result channel: valid, ready, median, out-of-sync flag and sample count
// ----------------------------------------------------------------------------
interface swmo_out_if;

  logic                  valid;
  logic                  ready;
  swmo_pkg::sample_t     median_offset;
  logic                  out_of_sync;
  swmo_pkg::count_out_t  sample_count;

  modport source (output valid, output median_offset, output out_of_sync,
                  output sample_count, input ready);
  modport sink (input valid, input median_offset, input out_of_sync,
                input sample_count, output ready);

endinterface

`default_nettype wire

// File: design/swmo_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmo_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module swmo_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 50,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/sliding_window_median_offset_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median_offset_core
// upper median of the last Window offset samples with out-of-sync flag
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  smp_i     in    valid/ready    offset_sample
//  res_o     out   valid/ready    median_offset, out_of_sync, sample_count
//  cfg       in    cfg_we_i       cfg_wdata_i (warn threshold)
//
//  a transaction compares each candidate in turn with all n samples held and
//  stops when the median is found; with fewer than five held it gives zero
//  the rank count reads the sample ram once per cycle through its one read port
//  a result waits in the output register; the next sample is taken meanwhile
//  reset clears the counters and the output valid and sets the threshold to 600
// ----------------------------------------------------------------------------
module sliding_window_median_offset_core #(
  parameter int unsigned Window = swmo_pkg::WindowDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  swmo_in_if.sink                    smp_i,
  swmo_out_if.source                 res_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [swmo_pkg::ThrW-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(Window);
  localparam int unsigned CntW = $clog2(Window + 1);
  localparam logic [CntW-1:0] WinLast = CntW'(Window - 1);
  localparam logic [CntW-1:0] WinFull = CntW'(Window);
  localparam logic [CntW-1:0] MinCnt  = CntW'(swmo_pkg::MinForMedian);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CAND  = 6'b000010,
    ST_CLAT  = 6'b000100,
    ST_INNER = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]     held_q, held_d;
  logic [IdxW-1:0]     oldest_q, oldest_d;
  logic [CntW-1:0]     i_q, i_d;
  logic [CntW-1:0]     j_q, j_d;
  logic [CntW-1:0]     below_q, below_d;
  logic [CntW-1:0]     same_q, same_d;
  logic                cmp_vld_q, cmp_vld_d;
  swmo_pkg::sample_t   cand_q, cand_d;
  swmo_pkg::sample_t   median_q, median_d;
  swmo_pkg::thr_t      thr_q;

  logic                out_vld_q, out_vld_d;
  swmo_pkg::sample_t   out_median_q, out_median_d;
  logic                out_flag_q, out_flag_d;
  swmo_pkg::count_out_t out_cnt_q, out_cnt_d;

  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [IdxW-1:0]     ram_raddr;
  logic [swmo_pkg::SampleW-1:0] ram_rdata;
  swmo_pkg::sample_t   rd_sample;

  logic                smp_acc;
  logic                out_free;
  logic [CntW-1:0]     rank;
  logic [CntW:0]       upper;
  logic                hit;
  swmo_pkg::sample_t   clamped;
  logic [swmo_pkg::SampleW-1:0] magnitude;
  logic                flag;

  assign smp_i.ready = (state_q == ST_IDLE);
  assign smp_acc     = smp_i.valid && smp_i.ready;
  assign out_free    = !out_vld_q || res_o.ready;

  assign rd_sample = swmo_pkg::sample_t'(ram_rdata);
  assign rank      = held_q >> 1;
  assign upper     = {1'b0, below_q} + {1'b0, same_q};
  assign hit       = (below_q <= rank) && ({1'b0, rank} < upper);

  // clamp most negative value before taking the magnitude
  always_comb begin
    clamped = median_q;
    if (median_q == {1'b1, {(swmo_pkg::SampleW - 1){1'b0}}}) begin
      clamped = {1'b1, {(swmo_pkg::SampleW - 2){1'b0}}, 1'b1};
    end
    magnitude = clamped[swmo_pkg::SampleW-1] ? (~clamped + 1'b1) : clamped;
    flag      = magnitude > {{(swmo_pkg::SampleW - swmo_pkg::ThrW){1'b0}}, thr_q};
  end

  assign ram_we    = smp_acc;
  assign ram_waddr = (held_q < WinFull) ? held_q[IdxW-1:0] : oldest_q;
  assign ram_raddr = (state_q == ST_CAND) ? i_q[IdxW-1:0] : j_q[IdxW-1:0];

  swmo_ram #(
    .Width (swmo_pkg::SampleW),
    .Depth (Window)
  ) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (smp_i.offset_sample),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    held_d       = held_q;
    oldest_d     = oldest_q;
    i_d          = i_q;
    j_d          = j_q;
    below_d      = below_q;
    same_d       = same_q;
    cmp_vld_d    = 1'b0;
    cand_d       = cand_q;
    median_d     = median_q;
    out_vld_d    = out_vld_q && !res_o.ready;
    out_median_d = out_median_q;
    out_flag_d   = out_flag_q;
    out_cnt_d    = out_cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (smp_acc) begin
          if (held_q < WinFull) begin
            held_d = held_q + 1'b1;
          end else if (oldest_q == WinLast[IdxW-1:0]) begin
            oldest_d = '0;
          end else begin
            oldest_d = oldest_q + 1'b1;
          end
          i_d      = '0;
          median_d = '0;
          state_d  = ((held_q + 1'b1) < MinCnt) ? ST_DONE : ST_CAND;
          if (held_q >= WinFull) begin
            state_d = ST_CAND;
          end
        end
      end
      ST_CAND: begin
        state_d = ST_CLAT;
      end
      ST_CLAT: begin
        cand_d  = rd_sample;
        j_d     = '0;
        below_d = '0;
        same_d  = '0;
        state_d = ST_INNER;
      end
      ST_INNER: begin
        if (j_q < held_q) begin
          j_d       = j_q + 1'b1;
          cmp_vld_d = 1'b1;
        end
        if (cmp_vld_q) begin
          if (rd_sample < cand_q) begin
            below_d = below_q + 1'b1;
          end else if (rd_sample == cand_q) begin
            same_d = same_q + 1'b1;
          end
        end
        if (!(j_q < held_q) && !cmp_vld_q) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (hit) begin
          median_d = cand_q;
          state_d  = ST_DONE;
        end else if ((i_q + 1'b1) >= held_q) begin
          median_d = '0;
          state_d  = ST_DONE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_CAND;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_median_d = median_q;
          out_flag_d   = flag;
          out_cnt_d    = swmo_pkg::count_out_t'(held_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      held_q    <= '0;
      oldest_q  <= '0;
      i_q       <= '0;
      j_q       <= '0;
      below_q   <= '0;
      same_q    <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      thr_q     <= swmo_pkg::ThrReset;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      oldest_q  <= oldest_d;
      i_q       <= i_d;
      j_q       <= j_d;
      below_q   <= below_d;
      same_q    <= same_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cand_q       <= cand_d;
    median_q     <= median_d;
    out_median_q <= out_median_d;
    out_flag_q   <= out_flag_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.median_offset = out_median_q;
  assign res_o.out_of_sync   = out_flag_q;
  assign res_o.sample_count  = out_cnt_q;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= WinFull)
    else $error("held count above window size");

  a_oldest_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q < WinFull) |-> (oldest_q == '0))
    else $error("oldest slot moved while window fills");

  a_cand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CAND) |-> (i_q < held_q))
    else $error("candidate index beyond held samples");

  a_count_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_cnt_q == swmo_pkg::count_out_t'(held_q)))
    else $error("result count differs from held count");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free && held_q < MinCnt) |=>
      (out_median_q == '0 && !out_flag_q))
    else $error("median reported with too few samples");
`endif

endmodule

`default_nettype wire

// File: test/tb_sliding_window_median_offset_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_offset_core
// drives offset samples into the median core and checks every result against
// a local window model (upper median, clamped magnitude test, sample count),
// over several warn thresholds, with random idling and output back-pressure
// ----------------------------------------------------------------------------
module tb_sliding_window_median_offset_core;

  localparam int unsigned WinDepth = swmo_pkg::WindowDef;
  localparam int unsigned SmpW     = swmo_pkg::SampleW;
  localparam swmo_pkg::sample_t OffsetMin = {1'b1, {(SmpW-1){1'b0}}};
  localparam swmo_pkg::sample_t OffsetMax = {1'b0, {(SmpW-1){1'b1}}};
  localparam swmo_pkg::thr_t ThrMax = '1;

  typedef struct packed {
    swmo_pkg::sample_t    median_offset;
    logic                 out_of_sync;
    swmo_pkg::count_out_t sample_count;
  } median_result_t;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we_i;
  swmo_pkg::thr_t cfg_wdata_i;

  swmo_in_if  smp_if ();
  swmo_out_if res_if ();

  sliding_window_median_offset_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_i       (smp_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // window model
  swmo_pkg::sample_t window_mem [WinDepth];
  int unsigned       oldest_idx;
  int unsigned       held_cnt;
  swmo_pkg::thr_t    warn_thr;

  swmo_pkg::sample_t offsets_to_send [$];
  swmo_pkg::sample_t offset_history [$];
  median_result_t    expected_results [$];

  int  send_gap;
  int  ready_stall;
  int  long_stall_req;
  bit  calm_mode;
  int  error_cnt;
  int  samples_sent;
  int  results_checked;
  int  input_stall_cycles;
  int  thr_writes;

  function automatic median_result_t take_sample(input swmo_pkg::sample_t s);
    swmo_pkg::sample_t sorted [WinDepth];
    swmo_pkg::sample_t key;
    swmo_pkg::sample_t clamped;
    logic [SmpW-1:0]   magnitude;
    median_result_t    r;
    int                i;
    int                j;
    if (held_cnt < WinDepth) begin
      window_mem[held_cnt] = s;
      held_cnt++;
    end else begin
      window_mem[oldest_idx] = s;
      oldest_idx = (oldest_idx + 1) % WinDepth;
    end
    r = '0;
    r.sample_count = swmo_pkg::count_out_t'(held_cnt);
    if (held_cnt >= swmo_pkg::MinForMedian) begin
      for (i = 0; i < held_cnt; i++) begin
        key = window_mem[i];
        j = i;
        while (j > 0 && sorted[j-1] > key) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      r.median_offset = sorted[held_cnt / 2];
      clamped = (r.median_offset == OffsetMin) ? OffsetMin + 1 : r.median_offset;
      magnitude = (clamped < 0) ? -clamped : clamped;
      r.out_of_sync = magnitude > {{(SmpW-swmo_pkg::ThrW){1'b0}}, warn_thr};
    end
    return r;
  endfunction

  function automatic swmo_pkg::sample_t rand_offset();
    swmo_pkg::sample_t v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = {$urandom, $urandom};
      3, 4: v = swmo_pkg::sample_t'($urandom_range(0, 4000)) - 2000;
      5, 6: begin
        v = swmo_pkg::sample_t'(warn_thr) + swmo_pkg::sample_t'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      7: begin
        case ($urandom_range(0, 4))
          0: v = OffsetMin;
          1: v = OffsetMax;
          2: v = '0;
          3: v = '1;
          default: v = OffsetMin + 1;
        endcase
      end
      default: begin
        if (offset_history.size() != 0)
          v = offset_history[$urandom_range(0, offset_history.size() - 1)];
        else
          v = '0;
      end
    endcase
    return v;
  endfunction

  task automatic queue_offset(input swmo_pkg::sample_t v);
    offsets_to_send.insert(offsets_to_send.size(), v);
    offset_history.insert(offset_history.size(), v);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (offsets_to_send.size() != 0 || expected_results.size() != 0 || smp_if.valid)
      @(negedge clk_i);
  endtask

  task automatic set_threshold(input swmo_pkg::thr_t v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    warn_thr = v;
    thr_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n);
    repeat (n) queue_offset(rand_offset());
    wait_drained();
  endtask

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_if.valid         <= 1'b0;
      smp_if.offset_sample <= '0;
      send_gap = 0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        expected_results.insert(expected_results.size(),
                                take_sample(smp_if.offset_sample));
        offsets_to_send.delete(0);
        samples_sent++;
      end else if (smp_if.valid) begin
        input_stall_cycles++;
      end
      if (!(smp_if.valid && !smp_if.ready)) begin
        if (send_gap > 0) begin
          smp_if.valid <= 1'b0;
          send_gap--;
        end else if (offsets_to_send.size() != 0) begin
          smp_if.valid         <= 1'b1;
          smp_if.offset_sample <= offsets_to_send[0];
          if (!calm_mode && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 17);
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    median_result_t exp_r;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      ready_stall = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no sample outstanding: median_offset %0d",
                 res_if.median_offset);
          error_cnt++;
        end else begin
          exp_r = expected_results[0];
          expected_results.delete(0);
          results_checked++;
          if (res_if.median_offset !== exp_r.median_offset) begin
            $error("median_offset: expected %0d, got %0d",
                   exp_r.median_offset, res_if.median_offset);
            error_cnt++;
          end
          if (res_if.out_of_sync !== exp_r.out_of_sync) begin
            $error("out_of_sync: expected %0b, got %0b",
                   exp_r.out_of_sync, res_if.out_of_sync);
            error_cnt++;
          end
          if (res_if.sample_count !== exp_r.sample_count) begin
            $error("sample_count: expected %0d, got %0d",
                   exp_r.sample_count, res_if.sample_count);
            error_cnt++;
          end
        end
      end
      if (long_stall_req != 0) begin
        ready_stall = long_stall_req;
        long_stall_req = 0;
      end
      if (ready_stall > 0) begin
        res_if.ready <= 1'b0;
        ready_stall--;
      end else begin
        res_if.ready <= 1'b1;
        if (!calm_mode && $urandom_range(0, 5) == 0) ready_stall = $urandom_range(1, 17);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    smp_if.valid         = 1'b0;
    smp_if.offset_sample = '0;
    res_if.ready         = 1'b0;
    oldest_idx           = 0;
    held_cnt             = 0;
    warn_thr             = swmo_pkg::ThrReset;
    long_stall_req       = 0;
    calm_mode            = 1'b0;
    error_cnt            = 0;
    samples_sent         = 0;
    results_checked      = 0;
    input_stall_cycles   = 0;
    thr_writes           = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset threshold, most negative median, values around the threshold
    repeat (5) queue_offset(OffsetMin);
    queue_offset(swmo_pkg::sample_t'(601));
    queue_offset(-swmo_pkg::sample_t'(601));
    queue_offset(swmo_pkg::sample_t'(600));
    queue_offset(-swmo_pkg::sample_t'(600));
    repeat (3) queue_offset(OffsetMax);
    wait_drained();

    set_threshold('0);
    queue_offset('0);
    queue_offset(swmo_pkg::sample_t'(1));
    queue_offset('1);
    queue_offset('0);
    queue_offset('0);
    wait_drained();

    set_threshold(ThrMax);
    queue_offset(swmo_pkg::sample_t'(ThrMax));
    queue_offset(swmo_pkg::sample_t'(ThrMax) + 1);
    queue_offset(-swmo_pkg::sample_t'(ThrMax));
    queue_offset(-swmo_pkg::sample_t'(ThrMax) - 1);
    queue_offset(OffsetMin + 1);
    wait_drained();

    // output held off while samples keep coming
    set_threshold(swmo_pkg::thr_t'($urandom_range(0, 3000)));
    long_stall_req = 6000;
    run_random(6);

    repeat (4) begin
      case ($urandom_range(0, 3))
        0: set_threshold(swmo_pkg::thr_t'($urandom));
        1: set_threshold('0);
        2: set_threshold(ThrMax);
        default: set_threshold(swmo_pkg::thr_t'($urandom_range(0, 3000)));
      endcase
      run_random(24);
    end

    set_threshold(swmo_pkg::thr_t'($urandom_range(0, 3000)));
    calm_mode = 1'b1;
    run_random(24);

    repeat (3000) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      error_cnt++;
    end
    $display("%0d offsets sent, %0d results checked under %0d threshold settings",
             samples_sent, results_checked, thr_writes + 1);
    $display("window wrapped past %0d slots; sample input held off %0d cycles",
             WinDepth, input_stall_cycles);
    if (error_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/swmo_pkg.sv
design/swmo_in_if.sv
design/swmo_out_if.sv
design/swmo_ram.sv
design/sliding_window_median_offset_core.sv
test/tb_sliding_window_median_offset_core.sv
